// File: rtl/fix_message_field_filter_assert.svh
// ----------------------------------------------------------------------------
// FIX message field filter: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FIX_MESSAGE_FIELD_FILTER_ASSERT_SVH
`define FIX_MESSAGE_FIELD_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMF_ASSERT_IMPLIES(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold from the cycle after the antecedent.
`define FMF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/fmf_pkg.sv
// ----------------------------------------------------------------------------
// FIX message field filter: shared package
// Types, character codes and register indexes used across the block.
// ----------------------------------------------------------------------------
package fmf_pkg;

	localparam logic [7:0] CHAR_SOH    = 8'h01;
	localparam logic [7:0] CHAR_BAR    = 8'h7C;
	localparam logic [7:0] CHAR_EQUALS = 8'h3D;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;

	localparam logic [31:0] TAG_SEQ  = 32'd34;
	localparam logic [31:0] TAG_TYPE = 32'd35;

	// Bit positions in the filter enable register.
	localparam int EN_TYPE     = 0;
	localparam int EN_SEQ_LOW  = 1;
	localparam int EN_SEQ_HIGH = 2;
	localparam int EN_TAG      = 3;
	localparam int EN_VALUE    = 4;

	localparam int IN_DEPTH  = 4;
	localparam int IN_PTR_W  = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;

	localparam int REG_INDEX_W = 3;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_FILTER_ENABLES      = 3'd0,
		REG_MSG_TYPE_TEXT       = 3'd1,
		REG_MSG_TYPE_LENGTH     = 3'd2,
		REG_SEQ_LOW_BOUND       = 3'd3,
		REG_SEQ_HIGH_BOUND      = 3'd4,
		REG_MATCH_TAG           = 3'd5,
		REG_WANTED_VALUE_TEXT   = 3'd6,
		REG_WANTED_VALUE_LENGTH = 3'd7
	} reg_index_t;

	typedef enum logic [2:0] {
		PH_TAG   = 3'b001,
		PH_VALUE = 3'b010,
		PH_SKIP  = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		TS_EMPTY = 2'd0,
		TS_VALID = 2'd1,
		TS_BAD   = 2'd2
	} tag_status_t;

	typedef enum logic [1:0] {
		FOUND_NONE = 2'd0,
		FOUND_OK   = 2'd1,
		FOUND_BAD  = 2'd2
	} found_t;

	typedef struct packed {
		logic [4:0]  enables;
		logic [63:0] type_text;
		logic [3:0]  type_len;
		logic [31:0] seq_low;
		logic [31:0] seq_high;
		logic [31:0] match_tag;
		logic [63:0] want_text;
		logic [3:0]  want_len;
	} cfg_t;

	// One classified message byte as it waits between front and back.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_delim;
		logic       is_equals;
		logic       is_digit;
		logic [3:0] digit;
	} byte_word_t;

	typedef struct packed {
		logic       valid;
		byte_word_t word;
	} head_t;

endpackage

// File: rtl/fix_message_field_filter.sv
// ----------------------------------------------------------------------------
// FIX message field filter
// Checks each FIX message, one byte per word, against the enabled filters.
// ----------------------------------------------------------------------------
// The block takes one message byte per cycle for as long as the input queue
// has space, and the back-end parser retires one byte per cycle unless a
// final byte waits for a result slot, so the sustained rate is one byte per
// clock. The final byte of a message passes through the four-word input
// queue, after which the parser takes it and snapshots the message, and
// then the verdict stage, which compares the sequence bounds and writes the
// result queue. The four-word result queue only stops the parser when a
// final byte would find no free slot for its verdict. There is no clearing
// pass after reset. The user must write configuration only while no message
// is in flight; the block itself does not enforce it.
module fix_message_field_filter #(
	parameter int MAX_VALUE_BYTES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [7:0]                      data_byte,
	input  logic                            last_byte,
	input  logic                            pop,
	output logic                            empty,
	output logic                            matched,
	input  logic                            cfg_write,
	input  logic [fmf_pkg::REG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_data
);
	import fmf_pkg::*;

	cfg_t   cfg_q;
	head_t  q_head;
	logic   q_pop;
	logic   final_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{seq_high: '1, default: '0};
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FILTER_ENABLES:      cfg_q.enables    <= cfg_data[4:0];
				REG_MSG_TYPE_TEXT:       cfg_q.type_text  <= cfg_data;
				REG_MSG_TYPE_LENGTH:     cfg_q.type_len   <= cfg_data[3:0];
				REG_SEQ_LOW_BOUND:       cfg_q.seq_low    <= cfg_data[31:0];
				REG_SEQ_HIGH_BOUND:      cfg_q.seq_high   <= cfg_data[31:0];
				REG_MATCH_TAG:           cfg_q.match_tag  <= cfg_data[31:0];
				REG_WANTED_VALUE_TEXT:   cfg_q.want_text  <= cfg_data;
				REG_WANTED_VALUE_LENGTH: cfg_q.want_len   <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	fmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.head      (q_head),
		.head_pop  (q_pop)
	);

	fmf_back #(
		.MAX_VALUE_BYTES (MAX_VALUE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (q_head),
		.head_pop (q_pop),
		.pop      (pop),
		.empty    (empty),
		.matched  (matched)
	);

	assign final_pop = q_pop && q_head.word.last;

	`include "fix_message_field_filter_assert.svh"

	// The parser never takes a word from an empty input queue.
	`FMF_ASSERT_IMPLIES(a_pop_needs_word, q_pop, q_head.valid, "pop from empty input queue")

	// If the result queue is empty as a final byte leaves, its verdict arrives via the verdict stage.
	`FMF_ASSERT_NEXT(a_verdict_arrives, $past(final_pop && empty), !empty, "verdict missing")

	// A verdict only appears as the result of a final byte.
	`FMF_ASSERT_IMPLIES(a_verdict_cause, $fell(empty), $past(final_pop, 2), "stray verdict")

endmodule

// File: rtl/fmf_front.sv
// ----------------------------------------------------------------------------
// FIX message field filter: front end
// Accepts message bytes, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module fmf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  logic [7:0]     data_byte,
	input  logic           last_byte,
	output fmf_pkg::head_t head,
	input  logic           head_pop
);
	import fmf_pkg::*;

	byte_word_t            word_in;
	byte_word_t            mem_q [IN_DEPTH];
	logic [IN_PTR_W-1:0]   wr_q;
	logic [IN_PTR_W-1:0]   rd_q;
	logic [IN_PTR_W:0]     count_q;
	logic                  accept;

	always_comb begin
		word_in.data      = data_byte;
		word_in.last      = last_byte;
		word_in.is_delim  = (data_byte == CHAR_SOH) || (data_byte == CHAR_BAR);
		word_in.is_equals = (data_byte == CHAR_EQUALS);
		word_in.is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
		word_in.digit     = data_byte[3:0];
	end

	assign full        = (count_q == (IN_PTR_W + 1)'(IN_DEPTH));
	assign accept      = push && !full;
	assign head.valid  = (count_q != '0);
	assign head.word   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wr_q] <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (accept) begin
				wr_q <= wr_q + 1'b1;
			end
			if (head_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({accept, head_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/fmf_back.sv
// ----------------------------------------------------------------------------
// FIX message field filter: back end
// Parses one byte per cycle unless stalled, judges messages, queues verdicts.
// ----------------------------------------------------------------------------
module fmf_back #(
	parameter int MAX_VALUE_BYTES = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fmf_pkg::cfg_t  cfg,
	input  fmf_pkg::head_t head,
	output logic           head_pop,
	input  logic           pop,
	output logic           empty,
	output logic           matched
);
	import fmf_pkg::*;

	localparam int VLEN_W = $clog2(MAX_VALUE_BYTES + 2);
	localparam logic [VLEN_W-1:0] VLEN_MAX  = VLEN_W'(MAX_VALUE_BYTES);
	localparam logic [VLEN_W-1:0] VLEN_OVER = VLEN_W'(MAX_VALUE_BYTES + 1);

	function automatic logic [35:0] times_ten_plus(input logic [31:0] acc,
		input logic [3:0] digit);
		logic [35:0] wide;
		wide = {4'b0000, acc};
		return (wide << 3) + (wide << 1) + {32'd0, digit};
	endfunction

	byte_word_t            w;

	phase_t                phase_q,     a_phase,     n_phase;
	logic [31:0]           tag_acc_q,   a_tag_acc,   n_tag_acc;
	tag_status_t           tag_st_q,    a_tag_st,    n_tag_st;
	logic [VLEN_W-1:0]     vlen_q,      a_vlen,      n_vlen;
	logic                  type_eq_q,   a_type_eq,   n_type_eq;
	logic                  want_eq_q,   a_want_eq,   n_want_eq;
	logic [31:0]           seq_acc_q,   a_seq_acc,   n_seq_acc;
	logic                  seq_ok_q,    a_seq_ok,    n_seq_ok;
	found_t                type_found_q, f_type_found, n_type_found;
	found_t                seq_found_q,  f_seq_found,  n_seq_found;
	logic                  tag_match_q,  f_tag_match,  n_tag_match;

	logic [35:0]           tag_n;
	logic [35:0]           seq_n;
	logic [2:0]            pos;
	logic [7:0]            type_ch;
	logic [7:0]            want_ch;
	logic                  seq_active;
	logic                  fin;
	logic                  fits;

	logic                  valid_s2;
	found_t                type_found_s2;
	found_t                seq_found_s2;
	logic [31:0]           seq_acc_s2;
	logic                  tag_match_s2;
	logic                  verdict_s2;

	logic                  res_mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  res_wr_q;
	logic [OUT_PTR_W-1:0]  res_rd_q;
	logic [OUT_PTR_W:0]    res_count_q;
	logic                  res_pop;
	logic                  room;

	assign w = head.word;

	// A final byte may only leave the queue when its verdict is sure of a slot.
	assign room = ((OUT_PTR_W + 2)'(res_count_q) + (OUT_PTR_W + 2)'(valid_s2))
		< (OUT_PTR_W + 2)'(OUT_DEPTH);
	assign head_pop = head.valid && (!w.last || room);

	assign tag_n      = times_ten_plus(tag_acc_q, w.digit);
	assign seq_n      = times_ten_plus(seq_acc_q, w.digit);
	assign pos        = 3'(vlen_q);
	assign type_ch    = cfg.type_text[{pos, 3'b000} +: 8];
	assign want_ch    = cfg.want_text[{pos, 3'b000} +: 8];
	assign seq_active = (tag_acc_q == TAG_SEQ) && (seq_found_q == FOUND_NONE);

	// Effect of the byte itself on the field state.
	always_comb begin
		a_phase   = phase_q;
		a_tag_acc = tag_acc_q;
		a_tag_st  = tag_st_q;
		a_vlen    = vlen_q;
		a_type_eq = type_eq_q;
		a_want_eq = want_eq_q;
		a_seq_acc = seq_acc_q;
		a_seq_ok  = seq_ok_q;
		if (!w.is_delim) begin
			unique case (phase_q)
				PH_TAG: begin
					if (w.is_equals) begin
						if (tag_st_q == TS_VALID) begin
							a_phase   = PH_VALUE;
							a_vlen    = '0;
							a_type_eq = 1'b1;
							a_want_eq = 1'b1;
							a_seq_ok  = 1'b1;
							if (seq_active) begin
								a_seq_acc = '0;
							end
						end else begin
							a_phase = PH_SKIP;
						end
					end else if (w.is_digit) begin
						if (tag_st_q != TS_BAD) begin
							if (tag_n[35:32] != 4'd0) begin
								a_tag_st = TS_BAD;
							end else begin
								a_tag_acc = tag_n[31:0];
								a_tag_st  = TS_VALID;
							end
						end
					end else begin
						a_tag_st = TS_BAD;
					end
				end
				PH_VALUE: begin
					if (vlen_q < VLEN_MAX) begin
						if (w.data != type_ch) begin
							a_type_eq = 1'b0;
						end
						if (w.data != want_ch) begin
							a_want_eq = 1'b0;
						end
						a_vlen = vlen_q + 1'b1;
					end else begin
						a_type_eq = 1'b0;
						a_want_eq = 1'b0;
						a_vlen    = VLEN_OVER;
					end
					if (seq_active) begin
						if (w.is_digit) begin
							if (seq_n[35:32] != 4'd0) begin
								a_seq_ok = 1'b0;
							end
							a_seq_acc = seq_n[31:0];
						end else begin
							a_seq_ok = 1'b0;
						end
					end
				end
				PH_SKIP: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Closing a field: either a delimiter ends it, or the message ends inside it.
	always_comb begin
		fin  = w.is_delim ? (phase_q == PH_VALUE) : (w.last && (a_phase == PH_VALUE));
		fits = (a_vlen <= VLEN_MAX);
		f_type_found = type_found_q;
		f_seq_found  = seq_found_q;
		f_tag_match  = tag_match_q;
		if (fin) begin
			if ((a_tag_acc == TAG_TYPE) && (type_found_q == FOUND_NONE)) begin
				f_type_found = (a_type_eq && fits && (4'(a_vlen) == cfg.type_len)) ?
					FOUND_OK : FOUND_BAD;
			end
			if ((a_tag_acc == TAG_SEQ) && (seq_found_q == FOUND_NONE)) begin
				f_seq_found = (a_seq_ok && (a_vlen != '0)) ? FOUND_OK : FOUND_BAD;
			end
			if (a_tag_acc == cfg.match_tag) begin
				if (!cfg.enables[EN_VALUE]) begin
					f_tag_match = 1'b1;
				end else if (a_want_eq && fits && (4'(a_vlen) == cfg.want_len)) begin
					f_tag_match = 1'b1;
				end
			end
		end
	end

	always_comb begin
		n_phase      = a_phase;
		n_tag_acc    = a_tag_acc;
		n_tag_st     = a_tag_st;
		n_vlen       = a_vlen;
		n_type_eq    = a_type_eq;
		n_want_eq    = a_want_eq;
		n_seq_acc    = a_seq_acc;
		n_seq_ok     = a_seq_ok;
		n_type_found = f_type_found;
		n_seq_found  = f_seq_found;
		n_tag_match  = f_tag_match;
		if (w.is_delim) begin
			n_phase   = PH_TAG;
			n_tag_acc = '0;
			n_tag_st  = TS_EMPTY;
		end
		if (w.last) begin
			n_phase      = PH_TAG;
			n_tag_acc    = '0;
			n_tag_st     = TS_EMPTY;
			n_vlen       = '0;
			n_type_eq    = 1'b1;
			n_want_eq    = 1'b1;
			n_seq_acc    = '0;
			n_seq_ok     = 1'b1;
			n_type_found = FOUND_NONE;
			n_seq_found  = FOUND_NONE;
			n_tag_match  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TAG;
			tag_acc_q    <= '0;
			tag_st_q     <= TS_EMPTY;
			vlen_q       <= '0;
			type_eq_q    <= 1'b1;
			want_eq_q    <= 1'b1;
			seq_acc_q    <= '0;
			seq_ok_q     <= 1'b1;
			type_found_q <= FOUND_NONE;
			seq_found_q  <= FOUND_NONE;
			tag_match_q  <= 1'b0;
		end else if (head_pop) begin
			phase_q      <= n_phase;
			tag_acc_q    <= n_tag_acc;
			tag_st_q     <= n_tag_st;
			vlen_q       <= n_vlen;
			type_eq_q    <= n_type_eq;
			want_eq_q    <= n_want_eq;
			seq_acc_q    <= n_seq_acc;
			seq_ok_q     <= n_seq_ok;
			type_found_q <= n_type_found;
			seq_found_q  <= n_seq_found;
			tag_match_q  <= n_tag_match;
		end
	end

	// Snapshot of a finished message; the bound compares run in the cycle after.
	always_ff @(posedge clk) begin
		if (head_pop && w.last) begin
			type_found_s2 <= f_type_found;
			seq_found_s2  <= f_seq_found;
			seq_acc_s2    <= a_seq_acc;
			tag_match_s2  <= f_tag_match;
		end
	end

	always_comb begin
		verdict_s2 = 1'b1;
		if (cfg.enables[EN_TYPE] && (type_found_s2 != FOUND_OK)) begin
			verdict_s2 = 1'b0;
		end
		if (cfg.enables[EN_SEQ_LOW] || cfg.enables[EN_SEQ_HIGH]) begin
			if (seq_found_s2 != FOUND_OK) begin
				verdict_s2 = 1'b0;
			end
			if (cfg.enables[EN_SEQ_LOW] && (seq_acc_s2 < cfg.seq_low)) begin
				verdict_s2 = 1'b0;
			end
			if (cfg.enables[EN_SEQ_HIGH] && (seq_acc_s2 > cfg.seq_high)) begin
				verdict_s2 = 1'b0;
			end
		end
		if (cfg.enables[EN_VALUE] && !cfg.enables[EN_TAG]) begin
			verdict_s2 = 1'b0;
		end
		if (cfg.enables[EN_TAG] && !tag_match_s2) begin
			verdict_s2 = 1'b0;
		end
	end

	assign empty   = (res_count_q == '0);
	assign res_pop = pop && !empty;
	assign matched = res_mem_q[res_rd_q];

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			res_mem_q[res_wr_q] <= verdict_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			res_wr_q    <= '0;
			res_rd_q    <= '0;
			res_count_q <= '0;
		end else begin
			valid_s2 <= head_pop && w.last;
			if (valid_s2) begin
				res_wr_q <= res_wr_q + 1'b1;
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + 1'b1;
			end
			case ({valid_s2, res_pop})
				2'b10:   res_count_q <= res_count_q + 1'b1;
				2'b01:   res_count_q <= res_count_q - 1'b1;
				default: res_count_q <= res_count_q;
			endcase
		end
	end

endmodule
